/* sv/pwlc_pkg.sv */
// Shared types and constants for the piecewise linear curve block.
`timescale 1ns / 1ps

package pwlc_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int VALUE_WIDTH = 16;

    // Fixed field widths.
    localparam int COUNT_W = 5;
    localparam int PIDX_W  = 4;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int EXT_W   = VALUE_WIDTH + 1;
    localparam int PROD_W  = 2 * EXT_W;
    localparam int QUO_W   = EXT_W;
    localparam int DCNT_W  = $clog2(QUO_W);
    localparam int ENTRY_W = 2 * VALUE_WIDTH;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [EXT_W-1:0]       ext_t;
    typedef logic signed [EXT_W:0]         wide_t;
    typedef logic        [EXT_W-1:0]       mag_t;
    typedef logic        [PROD_W-1:0]      prod_t;
    typedef logic        [QUO_W-1:0]       quo_t;
    typedef logic        [DCNT_W-1:0]      dcnt_t;
    typedef logic        [IDX_W-1:0]       idx_t;
    typedef logic        [IDX_W:0]         cnt_t;
    typedef logic        [COUNT_W-1:0]     count_t;
    typedef logic        [PIDX_W-1:0]      pidx_t;
    typedef logic        [ENTRY_W-1:0]     entry_t;

    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        CFG_NUM_POINTS = 2'd0,
        CFG_INPUT_MIN  = 2'd1,
        CFG_INPUT_MAX  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic   operation;
        value_t sample;
        pidx_t  point_index;
        value_t point_x;
        value_t point_y;
    } request_t;

    typedef struct packed {
        value_t mapped_value;
        logic   curve_error;
    } result_t;

    // Divider handshake.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic done;
        quo_t quotient;
    } div_sts_t;

endpackage

/* sv/piecewise_linear_curve.sv */
// Top level of the piecewise linear curve: control, breakpoint search, interpolation.
`timescale 1ns / 1ps

// Piecewise linear curve.
// Requests enter on start/request and are taken when start is high and busy is low.
// A write request stores one (x, y) breakpoint in the table RAM in that same cycle,
// gives no result, and leaves busy low, so requests may follow back to back.
// An evaluate request clamps the sample to [input_min, input_max], then scans the
// table one entry a cycle through the RAM's read port (read issued the cycle before).
// On a hit between two points it multiplies (v - x0) * |y1 - y0| in the S_MUL state and
// runs a restoring divider, one quotient bit per cycle.
// How an evaluate request ends: with fewer than two points in use, busy never
// rises; a sample at or below the first x, or past the last x, ends with the scan;
// a hit goes on through the multiply, the divider load and the divide, then the
// quotient is handed back and the result registered. The scan and the divider
// set how long a request takes.
// One evaluate request is in flight at a time; busy is high while it is, and the
// next request can be taken in the cycle its result shows.
// Each result shows on result for exactly one cycle with done high; there is no
// back-pressure, the receiver must take it then.
// The user writes configuration (cfg_write, cfg_index, cfg_data) only while busy is
// low; the block does not enforce it. Reset clears the control state, sets num_points
// to 0 and the clamp bounds to full range; the table holds garbage until written.
module piecewise_linear_curve (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pwlc_pkg::request_t  request,
    output logic                done,
    output pwlc_pkg::result_t   result,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  pwlc_pkg::value_t    cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIV  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    pwlc_pkg::count_t num_points_reg;
    pwlc_pkg::value_t input_min_reg;
    pwlc_pkg::value_t input_max_reg;

    // evaluate context
    pwlc_pkg::value_t v_reg,    v_next;
    pwlc_pkg::cnt_t   n_reg,    n_next;
    pwlc_pkg::cnt_t   idx_reg,  idx_next;   // entry whose data is on rdata
    pwlc_pkg::idx_t   addr_reg, addr_next;  // entry being read
    pwlc_pkg::value_t x0_reg,   x0_next;
    pwlc_pkg::value_t y0_reg,   y0_next;
    pwlc_pkg::mag_t   dv_reg,   dv_next;
    pwlc_pkg::mag_t   dx_reg,   dx_next;
    pwlc_pkg::mag_t   mag_reg,  mag_next;
    logic             neg_reg,  neg_next;
    pwlc_pkg::prod_t  prod_reg, prod_next;
    logic             go_reg,   go_next;

    logic              done_reg, done_next;
    pwlc_pkg::result_t res_reg,  res_next;

    // RAM
    logic             ram_we;
    pwlc_pkg::idx_t   ram_waddr;
    pwlc_pkg::entry_t ram_wdata;
    pwlc_pkg::idx_t   ram_raddr;
    pwlc_pkg::entry_t ram_rdata;

    pwlc_pkg::div_ctl_t div_ctl;
    pwlc_pkg::div_sts_t div_sts;

    logic             accept;
    pwlc_pkg::value_t clamped;
    pwlc_pkg::value_t rd_x;
    pwlc_pkg::value_t rd_y;
    logic             hit;
    pwlc_pkg::ext_t   dv_s;
    pwlc_pkg::ext_t   dx_s;
    pwlc_pkg::ext_t   dy_s;
    pwlc_pkg::wide_t  q_s;
    pwlc_pkg::wide_t  interp;

    assign accept = start && (state_reg == S_IDLE);

    // write requests go straight into the table
    assign ram_we    = accept && (request.operation == pwlc_pkg::OP_WRITE)
                       && (32'(request.point_index) < 32'(pwlc_pkg::MAX_POINTS));
    assign ram_waddr = pwlc_pkg::idx_t'(request.point_index);
    assign ram_wdata = {request.point_x, request.point_y};
    // while idle, keep entry 0 on the read port so the scan starts at once
    assign ram_raddr = (state_reg == S_IDLE) ? '0 : addr_reg;

    pwlc_ram #(
        .WIDTH (pwlc_pkg::ENTRY_W),
        .DEPTH (pwlc_pkg::MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_ctl.start = go_reg;

    pwlc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (prod_reg),
        .divisor  (dx_reg),
        .sts      (div_sts)
    );

    always_comb
    begin
        // crossed bounds: the low bound wins for samples below it
        if (request.sample < input_min_reg)
        begin
            clamped = input_min_reg;
        end
        else if (request.sample > input_max_reg)
        begin
            clamped = input_max_reg;
        end
        else
        begin
            clamped = request.sample;
        end

        rd_x = pwlc_pkg::value_t'(ram_rdata[pwlc_pkg::ENTRY_W-1:pwlc_pkg::VALUE_WIDTH]);
        rd_y = pwlc_pkg::value_t'(ram_rdata[pwlc_pkg::VALUE_WIDTH-1:0]);
        hit  = (rd_x >= v_reg);

        dv_s = pwlc_pkg::ext_t'(v_reg) - pwlc_pkg::ext_t'(x0_reg);
        dx_s = pwlc_pkg::ext_t'(rd_x)  - pwlc_pkg::ext_t'(x0_reg);
        dy_s = pwlc_pkg::ext_t'(rd_y)  - pwlc_pkg::ext_t'(y0_reg);

        q_s    = pwlc_pkg::wide_t'(signed'({1'b0, div_sts.quotient}));
        interp = neg_reg ? (pwlc_pkg::wide_t'(y0_reg) - q_s)
                         : (pwlc_pkg::wide_t'(y0_reg) + q_s);
    end

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        addr_next  = addr_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        dv_next    = dv_reg;
        dx_next    = dx_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        go_next    = 1'b0;
        done_next  = 1'b0;
        res_next   = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (request.operation == pwlc_pkg::OP_EVAL))
                begin
                    v_next = clamped;
                    // count too large acts as a full table
                    if (32'(num_points_reg) > 32'(pwlc_pkg::MAX_POINTS))
                    begin
                        n_next = pwlc_pkg::cnt_t'(pwlc_pkg::MAX_POINTS);
                    end
                    else
                    begin
                        n_next = pwlc_pkg::cnt_t'(num_points_reg);
                    end
                    if (n_next < pwlc_pkg::cnt_t'(2))
                    begin
                        // no curve: pass the clamped sample with error
                        res_next.mapped_value = clamped;
                        res_next.curve_error  = 1'b1;
                        done_next             = 1'b1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        addr_next  = pwlc_pkg::idx_t'(1);
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                if (hit && (idx_reg == '0))
                begin
                    // at or below the first x
                    res_next.mapped_value = rd_y;
                    res_next.curve_error  = 1'b0;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else if (hit)
                begin
                    dv_next    = pwlc_pkg::mag_t'(dv_s);
                    dx_next    = pwlc_pkg::mag_t'(dx_s);
                    neg_next   = dy_s[pwlc_pkg::EXT_W-1];
                    mag_next   = dy_s[pwlc_pkg::EXT_W-1] ? pwlc_pkg::mag_t'(-dy_s)
                                                         : pwlc_pkg::mag_t'(dy_s);
                    state_next = S_MUL;
                end
                else if (idx_reg == (n_reg - 1'b1))
                begin
                    // beyond the last x in use
                    res_next.mapped_value = v_reg;
                    res_next.curve_error  = 1'b1;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    x0_next  = rd_x;
                    y0_next  = rd_y;
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_MUL:
            begin
                prod_next  = pwlc_pkg::prod_t'(dv_reg) * pwlc_pkg::prod_t'(mag_reg);
                go_next    = 1'b1;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_sts.done)
                begin
                    res_next.mapped_value = pwlc_pkg::value_t'(interp);
                    res_next.curve_error  = 1'b0;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            go_reg         <= 1'b0;
            num_points_reg <= '0;
            input_min_reg  <= {1'b1, {(pwlc_pkg::VALUE_WIDTH-1){1'b0}}};
            input_max_reg  <= {1'b0, {(pwlc_pkg::VALUE_WIDTH-1){1'b1}}};
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            go_reg    <= go_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pwlc_pkg::CFG_NUM_POINTS:
                        num_points_reg <= cfg_data[pwlc_pkg::COUNT_W-1:0];
                    pwlc_pkg::CFG_INPUT_MIN:
                        input_min_reg <= cfg_data;
                    pwlc_pkg::CFG_INPUT_MAX:
                        input_max_reg <= cfg_data;
                    default:
                    begin
                        // unknown index: ignored
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        addr_reg <= addr_next;
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        dv_reg   <= dv_next;
        dx_reg   <= dx_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // a result always lands with the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // write requests never produce a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.operation == pwlc_pkg::OP_WRITE)) |=> !done)
        else $error("write request produced a result");

    // divider only finishes while waiting on it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");

    // scan never walks past the points in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg < n_reg))
        else $error("scan index beyond point count");

endmodule

/* sv/pwlc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pwlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/pwlc_div.sv */
// Restoring divider, one quotient bit per cycle; quotient known to fit QUO_W bits.
`timescale 1ns / 1ps

module pwlc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pwlc_pkg::div_ctl_t ctl,
    input  pwlc_pkg::prod_t   dividend,
    input  pwlc_pkg::mag_t    divisor,
    output pwlc_pkg::div_sts_t sts
);

    pwlc_pkg::mag_t  rem_reg,  rem_next;
    pwlc_pkg::quo_t  dq_reg,   dq_next;
    pwlc_pkg::dcnt_t cnt_reg,  cnt_next;
    logic            run_reg,  run_next;
    logic            done_reg, done_next;

    logic [pwlc_pkg::EXT_W:0]   shifted;
    logic [pwlc_pkg::EXT_W:0]   diff;
    logic                       ge;

    always_comb
    begin
        shifted   = {rem_reg, dq_reg[pwlc_pkg::QUO_W-1]};
        diff      = shifted - {1'b0, divisor};
        ge        = (shifted >= {1'b0, divisor});
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            // upper half is below the divisor, so it seeds the remainder
            rem_next = dividend[pwlc_pkg::PROD_W-1:pwlc_pkg::QUO_W];
            dq_next  = dividend[pwlc_pkg::QUO_W-1:0];
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[pwlc_pkg::EXT_W-1:0] : shifted[pwlc_pkg::EXT_W-1:0];
            dq_next  = {dq_reg[pwlc_pkg::QUO_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pwlc_pkg::dcnt_t'(pwlc_pkg::QUO_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign sts.done     = done_reg;
    assign sts.quotient = dq_reg;

endmodule

/* sim/tb_piecewise_linear_curve.sv */
// Self-checking testbench for the piecewise linear curve block.
`timescale 1ns / 1ps

module tb_piecewise_linear_curve;

    import pwlc_pkg::*;

    localparam int ITEMS      = 1800;   // requests planned in total
    localparam int CALM_ITEMS = 200;    // tail of the run sent without idle bursts
    localparam int SETTLE     = 40;     // quiet cycles after the last result of a phase
    localparam int STALL_MAX  = 2000;   // cycles with no progress before giving up

    // Config index with no register behind it; a write there must change nothing.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        ACT_REQUEST,
        ACT_SETTING,
        ACT_SYNC
    } act_kind_t;

    // One entry of the driver's work list.
    typedef struct {
        act_kind_t  kind;
        request_t   req;
        logic [1:0] reg_sel;
        value_t     reg_val;
        bit         calm;
    } act_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    request_t   request   = '0;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    value_t     cfg_data  = '0;
    logic       busy;
    logic       done;
    result_t    result;

    act_t    plan_q [$];     // work list for the driver
    result_t mapped_q [$];   // predicted results, oldest first

    // Predictor copy of the block's state and registers.
    value_t knot_x [MAX_POINTS];
    value_t knot_y [MAX_POINTS];
    count_t pt_count = '0;
    value_t lim_lo   = 16'sh8000;
    value_t lim_hi   = 16'sh7fff;

    // Planner-side view of the curve, used only to aim samples at breakpoints.
    value_t plan_x [MAX_POINTS];
    bit     calm_mode = 1'b0;
    int     planned   = 0;

    int  idle_left     = 0;
    bit  idle_on       = 1'b1;
    int  sent_count    = 0;
    int  knot_loads    = 0;
    int  checked_count = 0;
    int  flagged_count = 0;
    int  phase_count   = 0;
    int  fail_count    = 0;
    int  stall_count   = 0;

    piecewise_linear_curve dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic value_t clip16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return value_t'(v);
    endfunction

    function automatic value_t any16();
        return value_t'($urandom);
    endfunction

    // Clamp, search for the first breakpoint at or above the sample, interpolate
    // from the one before it with the quotient truncated toward zero.
    function automatic result_t curve_map(value_t raw);
        longint  v;
        longint  x0;
        longint  y0;
        longint  dx;
        longint  dv;
        longint  dy;
        longint  mag;
        longint  q;
        int      n;
        bit      hit;
        result_t r;
        v = raw;
        if (v < longint'(lim_lo))
            v = lim_lo;
        else if (v > longint'(lim_hi))
            v = lim_hi;
        n = (pt_count > MAX_POINTS) ? MAX_POINTS : int'(pt_count);
        r.mapped_value = value_t'(v);
        r.curve_error  = 1'b0;
        if (n < 2)
            r.curve_error = 1'b1;
        else if (longint'(knot_x[0]) >= v)
            r.mapped_value = knot_y[0];
        else
        begin
            hit = 1'b0;
            for (int i = 1; i < n; i++)
            begin
                if (!hit && longint'(knot_x[i]) >= v)
                begin
                    hit = 1'b1;
                    x0  = knot_x[i-1];
                    y0  = knot_y[i-1];
                    dx  = longint'(knot_x[i]) - x0;
                    dv  = v - x0;
                    dy  = longint'(knot_y[i]) - y0;
                    mag = (dy < 0) ? -dy : dy;
                    q   = (dv * mag) / dx;
                    r.mapped_value = value_t'((dy < 0) ? y0 - q : y0 + q);
                end
            end
            // Sample beyond the last x in use: clamped sample passes through.
            r.curve_error = !hit;
        end
        return r;
    endfunction

    task automatic push_request(request_t r);
        act_t a;
        a.kind    = ACT_REQUEST;
        a.req     = r;
        a.reg_sel = '0;
        a.reg_val = '0;
        a.calm    = calm_mode;
        plan_q.push_back(a);
        planned++;
    endtask

    // Evaluate request; the breakpoint fields carry noise the block must ignore.
    task automatic plan_eval(value_t s);
        request_t r;
        r.operation   = OP_EVAL;
        r.sample      = s;
        r.point_index = pidx_t'($urandom);
        r.point_x     = any16();
        r.point_y     = any16();
        push_request(r);
    endtask

    task automatic plan_knot(pidx_t idx, value_t x, value_t y);
        request_t r;
        r.operation   = OP_WRITE;
        r.sample      = any16();
        r.point_index = idx;
        r.point_x     = x;
        r.point_y     = y;
        push_request(r);
    endtask

    task automatic plan_setting(logic [1:0] sel, value_t val);
        act_t a;
        a.kind    = ACT_SETTING;
        a.req     = '0;
        a.reg_sel = sel;
        a.reg_val = val;
        a.calm    = calm_mode;
        plan_q.push_back(a);
    endtask

    task automatic plan_sync();
        act_t a;
        a.kind    = ACT_SYNC;
        a.req     = '0;
        a.reg_sel = '0;
        a.reg_val = '0;
        a.calm    = calm_mode;
        plan_q.push_back(a);
    endtask

    // Driver: takes the work list in order. A request holds start until taken;
    // register writes and syncs only run while no request is offered.
    always @(posedge clk)
    begin : drive
        act_t       nxt;
        logic       taken;
        logic       go;
        request_t   req_n;
        logic       wr_n;
        logic [1:0] sel_n;
        value_t     val_n;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_write <= 1'b0;
        end
        else
        begin
            taken = start && !busy;
            go    = start && !taken;
            req_n = request;
            wr_n  = 1'b0;
            sel_n = cfg_index;
            val_n = cfg_data;
            if ($urandom_range(0, 63) == 0)
                idle_on = !idle_on;

            // Predict at acceptance so the table and registers match the block's.
            if (taken)
            begin
                sent_count++;
                if (request.operation == OP_WRITE)
                begin
                    knot_x[request.point_index] = request.point_x;
                    knot_y[request.point_index] = request.point_y;
                    knot_loads++;
                end
                else
                    mapped_q.push_back(curve_map(request.sample));
            end

            if (!go)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (plan_q.size() != 0)
                begin
                    nxt = plan_q[0];
                    case (nxt.kind)
                        ACT_REQUEST:
                        begin
                            if (!nxt.calm && idle_on && $urandom_range(0, 5) == 0)
                                idle_left = $urandom_range(0, 10);
                            else
                            begin
                                plan_q.delete(0);
                                go    = 1'b1;
                                req_n = nxt.req;
                            end
                        end
                        ACT_SETTING:
                        begin
                            plan_q.delete(0);
                            wr_n  = 1'b1;
                            sel_n = nxt.reg_sel;
                            val_n = nxt.reg_val;
                            if (nxt.reg_sel == CFG_NUM_POINTS)
                                pt_count = nxt.reg_val[4:0];
                            else if (nxt.reg_sel == CFG_INPUT_MIN)
                                lim_lo = nxt.reg_val;
                            else if (nxt.reg_sel == CFG_INPUT_MAX)
                                lim_hi = nxt.reg_val;
                        end
                        default:
                        begin
                            // Wait for the last result; one strobed this edge counts
                            // as arrived whichever block runs first.
                            if (!taken && !busy && (mapped_q.size() == 0 ||
                                (mapped_q.size() == 1 && done)))
                            begin
                                plan_q.delete(0);
                                idle_left = SETTLE;
                            end
                        end
                    endcase
                end
            end

            start     <= go;
            request   <= req_n;
            cfg_write <= wr_n;
            cfg_index <= sel_n;
            cfg_data  <= val_n;
        end
    end

    // Monitor: every strobed result is matched against the oldest prediction.
    always @(posedge clk)
    begin : check
        result_t want;
        if (rst_n && done)
        begin
            if (mapped_q.size() == 0)
            begin
                $error("result with no evaluate request pending: mapped_value %0d curve_error %0b",
                       $signed(result.mapped_value), result.curve_error);
                fail_count++;
            end
            else
            begin
                want = mapped_q.pop_front();
                checked_count++;
                if (want.curve_error)
                    flagged_count++;
                if (result.mapped_value !== want.mapped_value)
                begin
                    $error("mapped_value: expected %0d, actual %0d",
                           $signed(want.mapped_value), $signed(result.mapped_value));
                    fail_count++;
                end
                if (result.curve_error !== want.curve_error)
                begin
                    $error("curve_error: expected %0b, actual %0b",
                           want.curve_error, result.curve_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no request, result or register write moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_write)
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_MAX)
            begin
                $display("stalled for %0d cycles with %0d results outstanding",
                         stall_count, mapped_q.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int     pick;
        int     cnt;
        int     span;
        int     xx;
        int     reps;
        bit     top;
        pidx_t  slot;
        value_t word;
        value_t a;
        value_t b;
        value_t lo;
        value_t hi;

        // Directed: no points in use, so both extremes pass through flagged.
        plan_eval(16'sh8000);
        plan_eval(16'sh7fff);
        // Full ladder from -32768 to 32767 with y swinging rail to rail; slot 7
        // drops back to slot 5's x so one stretch of the table is out of order.
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            plan_x[i] = (i == 7) ? plan_x[5] : clip16(-32768 + i * 4369);
            plan_knot(pidx_t'(i), plan_x[i], (i % 2 == 0) ? 16'sh7fff : 16'sh8000);
        end
        plan_sync();
        plan_setting(CFG_NUM_POINTS, 16'd1);          // one point is still too few
        plan_eval(16'sd0);
        plan_sync();
        plan_setting(CFG_NUM_POINTS, 16'd20);         // above the table size
        plan_eval(16'sh8000);                         // at the first x
        plan_eval(16'sh7fff);                         // exactly on the last x
        plan_eval(16'sd1234);
        plan_eval(clip16(int'(plan_x[6]) + 100));     // lands past the unsorted slot
        plan_sync();
        plan_setting(CFG_NUM_POINTS, 16'd3);
        plan_setting(CFG_INPUT_MIN, 16'sd100);        // crossed clamp bounds
        plan_setting(CFG_INPUT_MAX, -16'sd100);
        plan_eval(-16'sd5000);                        // both end up above the last x
        plan_eval(16'sd5000);
        plan_sync();
        plan_setting(CFG_SPARE, 16'h5a5a);
        plan_setting(CFG_INPUT_MIN, 16'sh8000);
        plan_setting(CFG_INPUT_MAX, 16'sh7fff);
        plan_eval(-16'sd26000);

        // Random phases: new registers, mostly a fresh sorted curve, then samples
        // aimed at breakpoints, bounds and rails.
        while (planned < ITEMS)
        begin
            calm_mode = (planned >= ITEMS - CALM_ITEMS);
            plan_sync();
            phase_count++;

            pick = $urandom_range(0, 19);
            if (pick == 0)
                cnt = 0;
            else if (pick == 1)
                cnt = 1;
            else if (pick == 2)
                cnt = 16;
            else if (pick == 3)
                cnt = $urandom_range(17, 31);
            else
                cnt = $urandom_range(2, 16);
            word = value_t'(cnt);
            if ($urandom_range(0, 3) == 0)
            begin
                // Bits above the count field are don't-care.
                word      = any16();
                word[4:0] = cnt[4:0];
            end
            plan_setting(CFG_NUM_POINTS, word);

            a = any16();
            b = any16();
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                lo = 16'sh8000;
                hi = 16'sh7fff;
            end
            else if (pick < 7)
            begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            else if (pick == 7)
            begin
                lo = (a < b) ? b : a;
                hi = (a < b) ? a : b;
            end
            else if (pick == 8)
            begin
                lo = 16'sh7fff;
                hi = 16'sh8000;
            end
            else
            begin
                lo = clip16(-int'($urandom_range(0, 600)));
                hi = clip16(int'($urandom_range(0, 600)));
            end
            plan_setting(CFG_INPUT_MIN, lo);
            plan_setting(CFG_INPUT_MAX, hi);
            if ($urandom_range(0, 3) == 0)
                plan_setting(CFG_SPARE, any16());

            if ($urandom_range(0, 4) != 0)
            begin
                span = $urandom_range(1, 9000);
                xx   = ($urandom_range(0, 3) == 0) ? -32768
                                                   : int'($urandom_range(0, 45000)) - 32768;
                top  = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < MAX_POINTS; i++)
                begin
                    if (top && i == MAX_POINTS - 1)
                        xx = 32767;
                    plan_x[i] = clip16(xx);
                    plan_knot(pidx_t'(i), plan_x[i], any16());
                    xx = xx + int'($urandom_range(0, span));
                end
            end
            else
            begin
                // Keep the old curve but scramble a few slots.
                for (int i = 0; i < 3; i++)
                begin
                    slot = pidx_t'($urandom);
                    plan_x[slot] = any16();
                    plan_knot(slot, plan_x[slot], any16());
                end
            end

            reps = $urandom_range(30, 90);
            repeat (reps)
            begin
                pick = $urandom_range(0, 39);
                if (pick == 0)
                begin
                    slot = pidx_t'($urandom);
                    plan_x[slot] = any16();
                    plan_knot(slot, plan_x[slot], any16());
                end
                else if (pick == 1)
                    plan_sync();
                else if (pick < 14)
                    plan_eval(any16());
                else if (pick < 30)
                    plan_eval(clip16(int'(plan_x[$urandom_range(0, MAX_POINTS - 1)])
                                     + int'($urandom_range(0, 8)) - 4));
                else if (pick < 34)
                    plan_eval(($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'sh7fff);
                else if (pick < 38)
                    plan_eval(clip16(int'((pick < 36) ? lo : hi)
                                     + int'($urandom_range(0, 4)) - 2));
                else
                begin
                    cnt = $urandom_range(0, MAX_POINTS - 2);
                    plan_eval(clip16((int'(plan_x[cnt]) + int'(plan_x[cnt + 1])) / 2));
                end
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        do
            @(posedge clk);
        while (plan_q.size() != 0 || start || mapped_q.size() != 0);
        repeat (SETTLE) @(posedge clk);

        if (mapped_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", mapped_q.size());
            fail_count++;
        end
        $display("covered %0d requests (%0d breakpoint loads) over %0d register settings",
                 sent_count, knot_loads, phase_count + 4);
        $display("checked %0d results, %0d of them flagged, %0d mismatches",
                 checked_count, flagged_count, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
